[rtl/rer_pkg.sv]
`default_nettype none

package rer_pkg;

   localparam int DATA_W = 32;
   localparam int SIZE_W = 4;
   localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd8;

   // reduction sequencer states
   typedef enum logic [4:0] {
      S_LOAD,
      S_PIV_RD,
      S_PIV_CHK,
      S_SRCH_RD,
      S_SRCH_CHK,
      S_SWP_RDA,
      S_SWP_RDB,
      S_SWP_WRA,
      S_SWP_WRB,
      S_SCL_RD,
      S_SCL_GO,
      S_SCL_WAIT,
      S_ELM_RD,
      S_ELM_CHK,
      S_MAC_RDP,
      S_MAC_RDR,
      S_MAC_GO,
      S_MAC_WAIT,
      S_OUT_RD,
      S_OUT_CAP,
      S_OUT_WAIT
   } seq_state_type;

   // arithmetic unit operations
   typedef enum logic {
      OP_DIV,
      OP_MAC
   } alu_op_type;

   typedef enum logic [1:0] {
      A_IDLE,
      A_DIV,
      A_MAC
   } alu_state_type;

   typedef struct packed {
      logic       start;
      alu_op_type op;
   } alu_cmd_type;

endpackage

`default_nettype wire

[rtl/rer_ram.sv]
`default_nettype none

module rer_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]              rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[rtl/rer_alu.sv]
`default_nettype none

// Shared arithmetic unit: bit-serial rounded fixed-point divide, or a
// registered multiply followed by round and saturating add.
module rer_alu #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire rer_pkg::alu_cmd_type     cmd,
   input  wire logic [rer_pkg::DATA_W-1:0] a_in,
   input  wire logic [rer_pkg::DATA_W-1:0] b_in,
   input  wire logic [rer_pkg::DATA_W-1:0] add_in,
   output logic [rer_pkg::DATA_W-1:0]    result,
   output logic                          done
);

   localparam int NW   = 32 + FRAC_BITS;
   localparam int CNTW = $clog2(NW + 1);
   localparam int RW   = 64 - FRAC_BITS;
   localparam int SW   = RW + 2;

   rer_pkg::alu_state_type st_ff, st_in;
   logic [NW-1:0]   dvd_ff, dvd_in;
   logic [31:0]     rem_ff, rem_in;
   logic [31:0]     den_ff, den_in;
   logic            neg_ff, neg_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic [63:0]     prod_ff, prod_in;
   logic [31:0]     add_ff, add_in_r;
   logic [31:0]     res_ff, res_in;
   logic            done_ff, done_in;

   logic [31:0]          amag, bmag;
   logic [32:0]          shifted, diff;
   logic                 ge;
   logic [63:0]          rnd_full;
   logic [RW-1:0]        rnd;
   logic signed [SW-1:0] sum, smax, smin;
   logic [31:0]          div_res;

   always_comb begin
      amag = a_in[31] ? (~a_in + 32'd1) : a_in;
      bmag = b_in[31] ? (~b_in + 32'd1) : b_in;

      // one restoring division step
      shifted = {rem_ff, dvd_ff[NW-1]};
      diff    = shifted - {1'b0, den_ff};
      ge      = (shifted >= {1'b0, den_ff});

      // round the product and add with saturation
      rnd_full = (prod_ff + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
      rnd      = rnd_full[RW-1:0];
      smax     = SW'(32'sh7FFF_FFFF);
      smin     = -smax - SW'(1);
      sum      = SW'($signed(add_ff))
               + (neg_ff ? -$signed({2'b00, rnd}) : $signed({2'b00, rnd}));

      // quotient magnitude to saturated signed word
      if (neg_ff) begin
         if (dvd_ff > NW'(64'h8000_0000)) div_res = 32'h8000_0000;
         else                             div_res = ~dvd_ff[31:0] + 32'd1;
      end else begin
         if (dvd_ff > NW'(64'h7FFF_FFFF)) div_res = 32'h7FFF_FFFF;
         else                             div_res = dvd_ff[31:0];
      end
   end

   always_comb begin
      st_in    = st_ff;
      dvd_in   = dvd_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      neg_in   = neg_ff;
      cnt_in   = cnt_ff;
      prod_in  = prod_ff;
      add_in_r = add_ff;
      res_in   = res_ff;
      done_in  = 1'b0;
      unique case (st_ff)
         rer_pkg::A_IDLE: begin
            if (cmd.start) begin
               if (cmd.op == rer_pkg::OP_DIV) begin
                  // load dividend with half the divisor for round to nearest
                  dvd_in = {amag, {FRAC_BITS{1'b0}}} + NW'(bmag >> 1);
                  rem_in = '0;
                  den_in = bmag;
                  neg_in = a_in[31] ^ b_in[31];
                  cnt_in = CNTW'(NW);
                  st_in  = rer_pkg::A_DIV;
               end else begin
                  // multiplier is the negated entry: negative when entry is positive
                  prod_in  = 64'(amag) * 64'(bmag);
                  neg_in   = a_in[31] ^ ~b_in[31];
                  add_in_r = add_in;
                  st_in    = rer_pkg::A_MAC;
               end
            end
         end
         rer_pkg::A_DIV: begin
            if (cnt_ff == '0) begin
               res_in  = div_res;
               done_in = 1'b1;
               st_in   = rer_pkg::A_IDLE;
            end else begin
               rem_in = ge ? diff[31:0] : shifted[31:0];
               dvd_in = {dvd_ff[NW-2:0], ge};
               cnt_in = cnt_ff - CNTW'(1);
            end
         end
         rer_pkg::A_MAC: begin
            if (sum > smax)      res_in = 32'h7FFF_FFFF;
            else if (sum < smin) res_in = 32'h8000_0000;
            else                 res_in = sum[31:0];
            done_in = 1'b1;
            st_in   = rer_pkg::A_IDLE;
         end
         default: st_in = rer_pkg::A_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= rer_pkg::A_IDLE;
         done_ff <= 1'b0;
      end else begin
         st_ff   <= st_in;
         done_ff <= done_in;
      end
      dvd_ff  <= dvd_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      neg_ff  <= neg_in;
      cnt_ff  <= cnt_in;
      prod_ff <= prod_in;
      add_ff  <= add_in_r;
      res_ff  <= res_in;
   end

   assign result = res_ff;
   assign done   = done_ff;

endmodule

`default_nettype wire

[rtl/row_echelon_reducer.sv]
`default_nettype none

// Channel   Direction  Handshake               Payload
// req       in         req_valid / req_stall   req_element_value
// rsp       out        rsp_valid / rsp_stall   rsp_result_value, rsp_is_last
// csr       in         csr_valid / csr_ready   csr_matrix_size
//
// Loading accepts one word per cycle; the last word of an N x N matrix starts
// the reduction, which runs on one memory and one arithmetic unit.
// A row-scaling step divides each element by the pivot, an elimination
// update does a multiply-add per element, and a search or swap steps
// entry by entry; each result word is held through any rsp stall. req_stall
// is high from the last load word until the last result word is taken.
// Reset (synchronous) empties the load count and sets matrix size to 8.
module row_echelon_reducer #(
   parameter int MAX_DIM   = 8,
   parameter int FRAC_BITS = 16
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic signed [rer_pkg::DATA_W-1:0] req_element_value,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic signed [rer_pkg::DATA_W-1:0] rsp_result_value,
   output logic                              rsp_is_last,
   input  wire logic                         csr_valid,
   output logic                              csr_ready,
   input  wire logic [rer_pkg::SIZE_W-1:0]   csr_matrix_size
);

   localparam int DEPTH = MAX_DIM * MAX_DIM;
   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = $clog2(MAX_DIM + 1);
   localparam int CNTW  = AW + 1;
   localparam int TW    = AW + 1;

   rer_pkg::seq_state_type state_ff, state_in;
   logic [rer_pkg::SIZE_W-1:0] size_ff;
   logic [CNTW-1:0] count_ff, count_in;
   logic [CW-1:0]   n_ff, n_in;
   logic [TW-1:0]   total_ff, total_in;
   logic [CW-1:0]   i_ff, i_in, r_ff, r_in, c_ff, c_in, found_ff, found_in;
   logic [AW-1:0]   k_ff, k_in;
   logic [31:0]     piv_ff, piv_in, tmp_ff, tmp_in, coef_ff, coef_in;
   logic [31:0]     out_ff, out_in;
   logic            last_ff, last_in;

   logic [CW-1:0]   n_eff, i_plus, r_plus, c_plus;
   logic [TW-1:0]   total_eff;
   logic [CNTW-1:0] count_plus;
   logic            next_col, next_row, elim_go, k_last;

   logic            we;
   logic [AW-1:0]   waddr, raddr;
   logic [31:0]     wdata, rdata;

   rer_pkg::alu_cmd_type alu_cmd;
   logic [31:0]          alu_a, alu_b, alu_add, alu_res;
   logic                 alu_done;

   function automatic logic [AW-1:0] lin_addr(input logic [CW-1:0] row,
                                              input logic [CW-1:0] col,
                                              input logic [CW-1:0] dim);
      logic [2*CW-1:0] t;
      t = (2*CW)'(row) * (2*CW)'(dim) + (2*CW)'(col);
      return AW'(t);
   endfunction

   rer_ram #(
      .WIDTH (rer_pkg::DATA_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (we),
      .wr_addr (waddr),
      .wr_data (wdata),
      .rd_addr (raddr),
      .rd_data (rdata)
   );

   rer_alu #(
      .FRAC_BITS (FRAC_BITS)
   ) u_alu (
      .clock  (clock),
      .reset  (reset),
      .cmd    (alu_cmd),
      .a_in   (alu_a),
      .b_in   (alu_b),
      .add_in (alu_add),
      .result (alu_res),
      .done   (alu_done)
   );

   // clamp the size register to the supported range
   always_comb begin
      if (size_ff == '0)                         n_eff = CW'(1);
      else if (32'(size_ff) > 32'(MAX_DIM))      n_eff = CW'(MAX_DIM);
      else                                       n_eff = CW'(size_ff);
      total_eff  = TW'(32'(n_eff) * 32'(n_eff));
      count_plus = count_ff + CNTW'(1);
      i_plus     = i_ff + CW'(1);
      r_plus     = r_ff + CW'(1);
      c_plus     = c_ff + CW'(1);
      k_last     = ((TW'(k_ff) + TW'(1)) == total_ff);
   end

   // sequencer: next state, memory port and arithmetic unit control
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      n_in     = n_ff;
      total_in = total_ff;
      i_in     = i_ff;
      r_in     = r_ff;
      c_in     = c_ff;
      found_in = found_ff;
      k_in     = k_ff;
      piv_in   = piv_ff;
      tmp_in   = tmp_ff;
      coef_in  = coef_ff;
      out_in   = out_ff;
      last_in  = last_ff;
      next_col = 1'b0;
      next_row = 1'b0;
      elim_go  = 1'b0;
      we       = 1'b0;
      waddr    = '0;
      wdata    = req_element_value;
      raddr    = '0;
      alu_cmd  = '{start: 1'b0, op: rer_pkg::OP_DIV};
      alu_a    = rdata;
      alu_b    = piv_ff;
      alu_add  = rdata;

      unique case (state_ff)
         rer_pkg::S_LOAD: begin
            if (req_valid) begin
               // store the word and start once the matrix is complete
               we       = (count_ff < CNTW'(DEPTH));
               waddr    = AW'(count_ff);
               count_in = count_plus;
               if (count_plus >= total_eff) begin
                  n_in     = n_eff;
                  total_in = total_eff;
                  i_in     = '0;
                  state_in = rer_pkg::S_PIV_RD;
               end
            end
         end
         rer_pkg::S_PIV_RD: begin
            raddr    = lin_addr(i_ff, i_ff, n_ff);
            state_in = rer_pkg::S_PIV_CHK;
         end
         rer_pkg::S_PIV_CHK: begin
            if (rdata != '0) begin
               piv_in = rdata;
               if (rdata != (32'd1 << FRAC_BITS)) begin
                  c_in     = '0;
                  state_in = rer_pkg::S_SCL_RD;
               end else begin
                  elim_go = 1'b1;
               end
            end else begin
               // zero pivot: look below for a swap row
               r_in = i_plus;
               if (i_plus >= n_ff) next_col = 1'b1;
               else                state_in = rer_pkg::S_SRCH_RD;
            end
         end
         rer_pkg::S_SRCH_RD: begin
            raddr    = lin_addr(r_ff, i_ff, n_ff);
            state_in = rer_pkg::S_SRCH_CHK;
         end
         rer_pkg::S_SRCH_CHK: begin
            if (rdata != '0) begin
               found_in = r_ff;
               c_in     = '0;
               state_in = rer_pkg::S_SWP_RDA;
            end else if (r_plus >= n_ff) begin
               next_col = 1'b1;
            end else begin
               r_in     = r_plus;
               state_in = rer_pkg::S_SRCH_RD;
            end
         end
         rer_pkg::S_SWP_RDA: begin
            raddr    = lin_addr(i_ff, c_ff, n_ff);
            state_in = rer_pkg::S_SWP_RDB;
         end
         rer_pkg::S_SWP_RDB: begin
            raddr    = lin_addr(found_ff, c_ff, n_ff);
            tmp_in   = rdata;
            state_in = rer_pkg::S_SWP_WRA;
         end
         rer_pkg::S_SWP_WRA: begin
            we       = 1'b1;
            waddr    = lin_addr(i_ff, c_ff, n_ff);
            wdata    = rdata;
            state_in = rer_pkg::S_SWP_WRB;
         end
         rer_pkg::S_SWP_WRB: begin
            we    = 1'b1;
            waddr = lin_addr(found_ff, c_ff, n_ff);
            wdata = tmp_ff;
            // after the last column, recheck the new pivot
            if (c_plus >= n_ff) begin
               state_in = rer_pkg::S_PIV_RD;
            end else begin
               c_in     = c_plus;
               state_in = rer_pkg::S_SWP_RDA;
            end
         end
         rer_pkg::S_SCL_RD: begin
            raddr    = lin_addr(i_ff, c_ff, n_ff);
            state_in = rer_pkg::S_SCL_GO;
         end
         rer_pkg::S_SCL_GO: begin
            alu_cmd  = '{start: 1'b1, op: rer_pkg::OP_DIV};
            state_in = rer_pkg::S_SCL_WAIT;
         end
         rer_pkg::S_SCL_WAIT: begin
            if (alu_done) begin
               we    = 1'b1;
               waddr = lin_addr(i_ff, c_ff, n_ff);
               wdata = alu_res;
               if (c_plus >= n_ff) begin
                  elim_go = 1'b1;
               end else begin
                  c_in     = c_plus;
                  state_in = rer_pkg::S_SCL_RD;
               end
            end
         end
         rer_pkg::S_ELM_RD: begin
            raddr    = lin_addr(r_ff, i_ff, n_ff);
            state_in = rer_pkg::S_ELM_CHK;
         end
         rer_pkg::S_ELM_CHK: begin
            if (rdata == '0) begin
               next_row = 1'b1;
            end else begin
               coef_in  = rdata;
               c_in     = i_ff;
               state_in = rer_pkg::S_MAC_RDP;
            end
         end
         rer_pkg::S_MAC_RDP: begin
            raddr    = lin_addr(i_ff, c_ff, n_ff);
            state_in = rer_pkg::S_MAC_RDR;
         end
         rer_pkg::S_MAC_RDR: begin
            raddr    = lin_addr(r_ff, c_ff, n_ff);
            tmp_in   = rdata;
            state_in = rer_pkg::S_MAC_GO;
         end
         rer_pkg::S_MAC_GO: begin
            alu_cmd  = '{start: 1'b1, op: rer_pkg::OP_MAC};
            alu_a    = tmp_ff;
            alu_b    = coef_ff;
            state_in = rer_pkg::S_MAC_WAIT;
         end
         rer_pkg::S_MAC_WAIT: begin
            if (alu_done) begin
               we    = 1'b1;
               waddr = lin_addr(r_ff, c_ff, n_ff);
               wdata = alu_res;
               if (c_plus >= n_ff) begin
                  next_row = 1'b1;
               end else begin
                  c_in     = c_plus;
                  state_in = rer_pkg::S_MAC_RDP;
               end
            end
         end
         rer_pkg::S_OUT_RD: begin
            raddr    = k_ff;
            state_in = rer_pkg::S_OUT_CAP;
         end
         rer_pkg::S_OUT_CAP: begin
            out_in   = rdata;
            last_in  = k_last;
            state_in = rer_pkg::S_OUT_WAIT;
         end
         rer_pkg::S_OUT_WAIT: begin
            // hold the word until taken
            if (!rsp_stall) begin
               if (last_ff) begin
                  count_in = '0;
                  state_in = rer_pkg::S_LOAD;
               end else begin
                  k_in     = k_ff + AW'(1);
                  state_in = rer_pkg::S_OUT_RD;
               end
            end
         end
         default: state_in = rer_pkg::S_LOAD;
      endcase

      // advance through rows below the pivot, then to the next column
      if (elim_go) begin
         r_in = i_plus;
         if (i_plus >= n_ff) next_col = 1'b1;
         else                state_in = rer_pkg::S_ELM_RD;
      end
      if (next_row) begin
         if (r_plus >= n_ff) begin
            next_col = 1'b1;
         end else begin
            r_in     = r_plus;
            state_in = rer_pkg::S_ELM_RD;
         end
      end
      if (next_col) begin
         i_in = i_plus;
         if (i_plus >= n_ff) begin
            k_in     = '0;
            state_in = rer_pkg::S_OUT_RD;
         end else begin
            state_in = rer_pkg::S_PIV_RD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rer_pkg::S_LOAD;
         count_ff <= '0;
         size_ff  <= rer_pkg::SIZE_RESET;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (csr_valid && csr_ready) begin
            size_ff <= csr_matrix_size;
         end
      end
      n_ff     <= n_in;
      total_ff <= total_in;
      i_ff     <= i_in;
      r_ff     <= r_in;
      c_ff     <= c_in;
      found_ff <= found_in;
      k_ff     <= k_in;
      piv_ff   <= piv_in;
      tmp_ff   <= tmp_in;
      coef_ff  <= coef_in;
      out_ff   <= out_in;
      last_ff  <= last_in;
   end

   assign req_stall        = (state_ff != rer_pkg::S_LOAD);
   assign rsp_valid        = (state_ff == rer_pkg::S_OUT_WAIT);
   assign rsp_result_value = out_ff;
   assign rsp_is_last      = last_ff;
   assign csr_ready        = 1'b1;

endmodule

`default_nettype wire
